FILE: src/u2da_pkg.sv
package u2da_pkg;

	// width of the converted number
	localparam int VALUE_BITS = 32;
	// decimal digits needed: ceil(VALUE_BITS * log10(2))
	localparam int NUM_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
	localparam int DIG_IDX_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int CNT_W      = $clog2(VALUE_BITS + 1);

	// ASCII '0'; low nibble clear, so a digit is simply ORed in
	localparam logic [5:0] CHAR_ZERO = 6'h30;

	typedef logic [3:0] bcd_t;
	typedef bcd_t [NUM_DIGITS-1:0] digits_t;

	// finished digit row handed from the cell chain to the output stage
	typedef struct packed {
		logic    load;
		digits_t digits;
	} dig_beat_t;

endpackage

FILE: src/u2da_cell.sv
// One BCD digit of the shift-and-add-3 chain.
module u2da_cell (
	input  logic              clk,
	input  logic              clr,
	input  logic              en,
	input  logic              cin,
	output logic              cout,
	output u2da_pkg::bcd_t    digit
);

	u2da_pkg::bcd_t digit_q;
	u2da_pkg::bcd_t adj;

	always_comb begin
		adj  = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
		cout = adj[3];
	end

	always_ff @(posedge clk) begin
		if (clr) begin
			digit_q <= '0;
		end else if (en) begin
			digit_q <= {adj[2:0], cin};
		end
	end

	assign digit = digit_q;

endmodule

FILE: src/u2da_emit.sv
// Output stage: holds one digit row, skips leading zeros, sends MSD first.
module u2da_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  u2da_pkg::dig_beat_t beat,
	output logic                ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [5:0]          digit_char,
	output logic                last
);

	u2da_pkg::digits_t                 digits_q;
	logic [u2da_pkg::DIG_IDX_W-1:0]    idx_q;
	logic [u2da_pkg::DIG_IDX_W-1:0]    msd;
	logic                              valid_q;
	logic                              take;

	// highest non-zero digit; zero value gives index 0
	always_comb begin
		msd = '0;
		for (int i = 0; i < u2da_pkg::NUM_DIGITS; i++) begin
			if (beat.digits[i] != '0) begin
				msd = u2da_pkg::DIG_IDX_W'(i);
			end
		end
	end

	assign take  = valid_q && !out_stall;
	assign ready = !valid_q || (take && (idx_q == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (beat.load) begin
			valid_q <= 1'b1;
			idx_q   <= msd;
		end else if (take) begin
			if (idx_q == '0) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat.load) begin
			digits_q <= beat.digits;
		end
	end

	assign out_valid  = valid_q;
	assign digit_char = u2da_pkg::CHAR_ZERO | {2'b00, digits_q[idx_q]};
	assign last       = (idx_q == '0);

endmodule

FILE: src/unsigned_to_decimal_ascii_top.sv
// Unsigned binary to decimal ASCII. Each input beat carries one VALUE_BITS-wide
// unsigned number; the block returns its decimal text as one output beat per
// digit ('0'..'9' as ASCII), most significant digit first, without leading
// zeros, and flags the final digit with last. A zero gives the single beat '0'.
// Conversion runs in a chain of NUM_DIGITS BCD cells (ten at 32 bits) using
// shift-and-add-3: the number enters one bit per cycle. A value goes from
// acceptance to the finished digit row through a load, one shift per bit, and
// the hand-over of the row to the output stage. While out_stall is low the
// output stage sends up to one digit per cycle, and it drains while the next
// value converts; the block takes a new value only once the previous row has
// been handed over. in_stall is high for the whole conversion and for as
// long as the output stage still holds digits of the previous value when a
// new row is ready. The first digit appears in the cycle after the hand-over.
module unsigned_to_decimal_ascii_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [u2da_pkg::VALUE_BITS-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [5:0]                      digit_char,
	output logic                            last
);

	// conversion control
	logic                           busy_q;
	logic [u2da_pkg::CNT_W-1:0]     cnt_q;
	logic [u2da_pkg::VALUE_BITS-1:0] bin_q;

	logic accept;
	logic shifting;
	logic done;
	logic handoff;
	logic emit_ready;

	// carry[i] feeds cell i; the top carry must stay clear (no overflow)
	logic [u2da_pkg::NUM_DIGITS:0] carry;
	u2da_pkg::digits_t             digits;
	u2da_pkg::dig_beat_t           beat;

	assign in_stall = busy_q;
	assign accept   = in_valid && !in_stall;
	assign shifting = busy_q && (cnt_q != u2da_pkg::CNT_W'(u2da_pkg::VALUE_BITS));
	assign done     = busy_q && (cnt_q == u2da_pkg::CNT_W'(u2da_pkg::VALUE_BITS));
	assign handoff  = done && emit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (shifting) begin
			cnt_q  <= cnt_q + 1'b1;
		end else if (handoff) begin
			busy_q <= 1'b0;
		end
	end

	// binary shifter, MSB first into the cell chain
	always_ff @(posedge clk) begin
		if (accept) begin
			bin_q <= value;
		end else if (shifting) begin
			bin_q <= {bin_q[u2da_pkg::VALUE_BITS-2:0], 1'b0};
		end
	end

	assign carry[0] = bin_q[u2da_pkg::VALUE_BITS-1];

	// cell 0 is the units digit
	for (genvar g = 0; g < u2da_pkg::NUM_DIGITS; g++) begin : g_cell
		u2da_cell u_cell (
			.clk   (clk),
			.clr   (accept),
			.en    (shifting),
			.cin   (carry[g]),
			.cout  (carry[g+1]),
			.digit (digits[g])
		);
	end

	assign beat.load   = handoff;
	assign beat.digits = digits;

	u2da_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (beat),
		.ready      (emit_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

`ifndef NO_ASSERTIONS
	// the chain is sized for the widest value: nothing ever leaves the top cell
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		shifting |-> !carry[u2da_pkg::NUM_DIGITS])
		else $error("digit chain overflow");

	// an accepted beat blocks the input for the conversion
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input not stalled during conversion");

	// a handed-over row always shows up at the output
	a_handoff_emits: assert property (@(posedge clk) disable iff (!arst_n)
		handoff |=> out_valid)
		else $error("digit row lost at hand-over");

	// only decimal digit characters leave the block
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char[5:4] == 2'b11 && digit_char[3:0] <= 4'd9))
		else $error("non-decimal character on output");
`endif

endmodule
